// ===== rtl/core/shs_pkg.sv =====
package shs_pkg;

   localparam int PortPinsDefault = 16;

   localparam int ActionW  = 3;
   localparam int AmountW  = 32;
   localparam int PeriodW  = 32;
   localparam int TurnW    = 16;
   localparam int PinMapW  = 16;
   localparam int MaskW    = 16;
   localparam int CoilW    = 4;
   localparam int PhaseW   = 3;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 32;

   localparam logic [PeriodW-1:0] StepPeriodReset   = 32'd1;
   localparam logic [TurnW-1:0]   StepsPerTurnReset = 16'd4096;
   localparam logic [PinMapW-1:0] PinMapReset       = 16'h3210;

   typedef enum logic [ActionW-1:0] {
      ACT_TICK         = 3'd0,
      ACT_START        = 3'd1,
      ACT_STOP         = 3'd2,
      ACT_SET_DIR      = 3'd3,
      ACT_REVERSE      = 3'd4,
      ACT_ROTATE_STEPS = 3'd5,
      ACT_ROTATE_TURNS = 3'd6
   } action_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_STEP_PERIOD    = 2'd0,
      CSR_STEPS_PER_TURN = 2'd1,
      CSR_PIN_MAP        = 2'd2
   } csr_index_type;

   typedef logic [CoilW-1:0] coil_type;

   localparam coil_type HalfStepSeq [8] = '{
      4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8
   };

   // Anticlockwise motion reads the sequence from its far end.
   function automatic coil_type half_step_pattern(input logic [PhaseW-1:0] phase,
                                                  input logic anticlockwise);
      logic [PhaseW-1:0] idx;
      idx = anticlockwise ? ~phase : phase;
      return HalfStepSeq[idx];
   endfunction

endpackage

// ===== rtl/core/shs_req_if.sv =====
interface shs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [shs_pkg::ActionW-1:0]          action;
   logic                                 direction;
   logic signed [shs_pkg::AmountW-1:0]   amount;

   modport source (output valid, action, direction, amount, input ready);
   modport sink   (input valid, action, direction, amount, output ready);
endinterface

// ===== rtl/core/shs_rsp_if.sv =====
interface shs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 step_taken;
   logic [shs_pkg::CoilW-1:0]            coil_pattern;
   logic [shs_pkg::MaskW-1:0]            set_mask;
   logic [shs_pkg::MaskW-1:0]            reset_mask;
   logic signed [shs_pkg::AmountW-1:0]   position;
   logic                                 running;
   logic                                 at_target;

   modport source (output valid, step_taken, coil_pattern, set_mask, reset_mask,
                   position, running, at_target, input ready);
   modport sink   (input valid, step_taken, coil_pattern, set_mask, reset_mask,
                   position, running, at_target, output ready);
endinterface

// ===== rtl/core/stepper_half_step_sequencer.sv =====
// Channel    Direction  Contents
// req_chan   in         action, direction, amount (valid/ready)
// rsp_chan   out        step, coil pattern, pin masks, position, status (valid/ready)
// csr_*      in         write enable, register index, write data
//
// An item is registered at the input, the next state and result are formed from it
// combinationally, and the result is registered before it is offered on rsp_chan.
// One item is taken every cycle while the result register drains or is empty.
// A stall on the result side holds both stages; reset is synchronous and restores
// the configuration registers, valid flags and motor state to their reset values.
module stepper_half_step_sequencer #(
   parameter int PORT_PINS = shs_pkg::PortPinsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   shs_req_if.sink                         req_chan,
   shs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [shs_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [shs_pkg::CsrDataW-1:0]    csr_wdata
);
   import shs_pkg::*;

   // Configuration registers.
   logic [PeriodW-1:0] step_period_ff;
   logic [TurnW-1:0]   steps_per_turn_ff;
   logic [PinMapW-1:0] pin_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff    <= StepPeriodReset;
         steps_per_turn_ff <= StepsPerTurnReset;
         pin_map_ff        <= PinMapReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STEP_PERIOD:    step_period_ff    <= csr_wdata[PeriodW-1:0];
            CSR_STEPS_PER_TURN: steps_per_turn_ff <= csr_wdata[TurnW-1:0];
            CSR_PIN_MAP:        pin_map_ff        <= csr_wdata[PinMapW-1:0];
            default: ;
         endcase
      end
   end

   // Input stage.  The turn offset is multiplied here so that only an add
   // remains in the state update.
   logic                s1_valid_ff;
   logic [ActionW-1:0]  s1_action_ff;
   logic                s1_direction_ff;
   logic                s1_negative_ff;
   logic [AmountW-1:0]  s1_offset_ff;
   logic [AmountW-1:0]  offset_in;
   logic                out_free;
   logic                s1_advance;
   logic                req_take;

   assign out_free   = !rsp_chan.valid || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take   = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_chan.action == ACT_ROTATE_TURNS)
         offset_in = AmountW'(AmountW'(req_chan.amount) * {16'd0, steps_per_turn_ff});
      else
         offset_in = AmountW'(req_chan.amount);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff    <= req_chan.action;
         s1_direction_ff <= req_chan.direction;
         s1_negative_ff  <= req_chan.amount[AmountW-1];
         s1_offset_ff    <= offset_in;
      end
   end

   // Motor state.
   logic [PhaseW-1:0]  phase_ff,  phase_in;
   logic [AmountW-1:0] step_ff,   step_in;
   logic [AmountW-1:0] target_ff, target_in;
   logic               anti_ff,   anti_in;
   logic [PeriodW-1:0] tick_ff,   tick_in;
   logic               enabled_ff, enabled_in;

   logic               stepped;
   logic [CoilW-1:0]   pattern;
   logic [MaskW-1:0]   set_m;
   logic [MaskW-1:0]   reset_m;
   logic [PeriodW-1:0] tick_inc;
   logic               new_dir;
   logic [3:0]         pin;

   assign tick_inc = tick_ff + PeriodW'(1);

   always_comb begin
      phase_in   = phase_ff;
      step_in    = step_ff;
      target_in  = target_ff;
      anti_in    = anti_ff;
      tick_in    = tick_ff;
      enabled_in = enabled_ff;
      stepped    = 1'b0;
      pattern    = '0;
      set_m      = '0;
      reset_m    = '0;
      new_dir    = s1_negative_ff;
      pin        = '0;

      case (s1_action_ff)
         ACT_TICK: begin
            if (!enabled_ff || step_ff == target_ff) begin
               tick_in = '0;
            end else if (tick_inc != step_period_ff) begin
               tick_in = tick_inc;
            end else begin
               stepped = 1'b1;
               pattern = half_step_pattern(phase_ff, anti_ff);
               for (int i = 0; i < CoilW; i++) begin
                  pin = pin_map_ff[4*i +: 4];
                  if ({28'd0, pin} < 32'(PORT_PINS)) begin
                     if (pattern[i])
                        set_m[pin] = 1'b1;
                     else
                        reset_m[pin] = 1'b1;
                  end
               end
               phase_in = phase_ff + PhaseW'(1);
               tick_in  = '0;
               step_in  = anti_ff ? step_ff - AmountW'(1) : step_ff + AmountW'(1);
            end
         end
         ACT_START: begin
            if (!enabled_ff) begin
               enabled_in = 1'b1;
               tick_in    = '0;
            end
         end
         ACT_STOP: begin
            if (enabled_ff) begin
               enabled_in = 1'b0;
               tick_in    = '0;
            end
         end
         ACT_SET_DIR: begin
            if (anti_ff != s1_direction_ff) begin
               anti_in  = s1_direction_ff;
               tick_in  = '0;
               phase_in = '0;
            end
         end
         ACT_REVERSE: begin
            anti_in  = !anti_ff;
            tick_in  = '0;
            phase_in = '0;
         end
         ACT_ROTATE_STEPS, ACT_ROTATE_TURNS: begin
            enabled_in = 1'b1;
            if (anti_ff != new_dir) begin
               anti_in  = new_dir;
               tick_in  = '0;
               phase_in = '0;
            end
            target_in = step_ff + s1_offset_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         step_ff    <= '0;
         target_ff  <= '0;
         anti_ff    <= 1'b0;
         tick_ff    <= '0;
         enabled_ff <= 1'b1;
      end else if (s1_advance) begin
         phase_ff   <= phase_in;
         step_ff    <= step_in;
         target_ff  <= target_in;
         anti_ff    <= anti_in;
         tick_ff    <= tick_in;
         enabled_ff <= enabled_in;
      end
   end

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_step_ff;
   logic [CoilW-1:0]     rsp_pattern_ff;
   logic [MaskW-1:0]     rsp_set_ff;
   logic [MaskW-1:0]     rsp_reset_ff;
   logic [AmountW-1:0]   rsp_position_ff;
   logic                 rsp_running_ff;
   logic                 rsp_at_target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_step_ff      <= stepped;
         rsp_pattern_ff   <= pattern;
         rsp_set_ff       <= set_m;
         rsp_reset_ff     <= reset_m;
         rsp_position_ff  <= step_in;
         rsp_running_ff   <= enabled_in;
         rsp_at_target_ff <= (step_in == target_in);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.step_taken   = rsp_step_ff;
   assign rsp_chan.coil_pattern = rsp_pattern_ff;
   assign rsp_chan.set_mask     = rsp_set_ff;
   assign rsp_chan.reset_mask   = rsp_reset_ff;
   assign rsp_chan.position     = signed'(rsp_position_ff);
   assign rsp_chan.running      = rsp_running_ff;
   assign rsp_chan.at_target    = rsp_at_target_ff;

endmodule
